// ----- rtl/core/ipv6_custody_option_editor_top_assert.svh -----
// Assertion macros for the custody option editor.
`ifndef IPV6_CUSTODY_OPTION_EDITOR_TOP_ASSERT_SVH
`define IPV6_CUSTODY_OPTION_EDITOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define COE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define COE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define COE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define COE_ASSERT_ALWAYS(label, expr, msg)
`define COE_ASSERT_IMPLY(label, ante, cons, msg)
`define COE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/coe_pkg.sv -----
package coe_pkg;

    typedef logic [7:0] t_byte;

    localparam int IP_HEADER_BYTES     = 40;
    localparam int OPTION_HEADER_BYTES = 24;
    localparam int STORE_BYTES         = IP_HEADER_BYTES + OPTION_HEADER_BYTES;
    localparam int ADDR_BYTES          = 16;
    localparam int POS_W               = $clog2(STORE_BYTES + 1);
    localparam int IDX_W               = $clog2(STORE_BYTES);

    localparam int PLEN_HI_OFS   = 4;
    localparam int PLEN_LO_OFS   = 5;
    localparam int NEXTH_OFS     = 6;
    localparam int OPT_NH_OFS    = IP_HEADER_BYTES;
    localparam int OPT_LEN_OFS   = IP_HEADER_BYTES + 1;
    localparam int OPT_TYPE_OFS  = IP_HEADER_BYTES + 2;
    localparam int OPT_ALEN_OFS  = IP_HEADER_BYTES + 3;
    localparam int ADDR_OFS      = IP_HEADER_BYTES + 4;
    localparam int ADDR_END      = ADDR_OFS + ADDR_BYTES;

    localparam t_byte OPT_LEN_CODE  = t_byte'(OPTION_HEADER_BYTES / 8 - 1);
    localparam t_byte ADDR_LEN_CODE = t_byte'(ADDR_BYTES);

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_STRIP,
        MODE_UPDATE,
        MODE_EXTRACT
    } t_mode;

    typedef enum logic [1:0] {
        CFG_EDIT_MODE,
        CFG_CUST_HIGH,
        CFG_CUST_LOW,
        CFG_TYPE_CODE
    } t_cfg_index;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_SHORT,
        STAT_NO_HBH,
        STAT_WRONG_OPT
    } t_status;

    typedef enum logic [1:0] {
        S_BUFFER,
        S_ALIGN,
        S_EMIT,
        S_PASS
    } t_state;

    typedef t_byte [STORE_BYTES-1:0] t_chain;

    typedef struct packed {
        logic  shift;
        t_byte din;
    } t_chain_ctl;

    function automatic t_byte addr_byte(input logic [8*ADDR_BYTES-1:0] addr,
                                        input logic [3:0] k);
        return addr[{~k, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/core/coe_in_if.sv -----
interface coe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/core/coe_out_if.sv -----
interface coe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       is_custodian_byte;
    logic [1:0] edit_status;

    modport source (output valid, output out_byte, output out_last,
                    output is_custodian_byte, output edit_status, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input is_custodian_byte, input edit_status, output ready);
endinterface

// ----- rtl/core/coe_cfg_if.sv -----
interface coe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/ipv6_custody_option_editor_top.sv -----
// IPv6 custody option editor. Packet bytes enter on i_in, one item per byte with in_last on
// the final byte, and edited bytes leave on o_out. Registers are written on i_cfg, which is
// always ready; the user must write them only while no packet is in flight, and the block
// itself does not enforce it. The first header bytes shift into a row of 64 byte cells
// at one item per cycle and produce no output. At the edit point (the 40th byte for an
// insertion, else the 64th byte, or an earlier final byte) input stalls while the row is
// unloaded: the row first shifts until the oldest byte reaches its end, then one byte
// leaves per cycle while the receiver is ready, for 64 bytes, or 40 when stripping an
// option, or the bytes held for a short packet. Bytes after the edit point pass through
// the output register, one per cycle while the receiver is ready.
// A stalled receiver holds the output register; the unload and the pass-through wait for it.
// edit_status is valid on the final byte only and reads zero elsewhere.
// Reset returns the registers to add mode, a zero custodian and option type 30, and the block
// waits for the first byte of a packet; the cell row needs no clearing.
`include "ipv6_custody_option_editor_top_assert.svh"

module ipv6_custody_option_editor_top
    import coe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    coe_in_if.sink       i_in,
    coe_out_if.source    o_out,
    coe_cfg_if.sink      i_cfg
);

    localparam int ADD_PLEN_HI   = IP_HEADER_BYTES - 2 - PLEN_HI_OFS;
    localparam int ADD_PLEN_LO   = IP_HEADER_BYTES - 2 - PLEN_LO_OFS;
    localparam int ADD_NEXTH     = IP_HEADER_BYTES - 2 - NEXTH_OFS;
    localparam int FULL_PLEN_HI  = STORE_BYTES - 2 - PLEN_HI_OFS;
    localparam int FULL_PLEN_LO  = STORE_BYTES - 2 - PLEN_LO_OFS;
    localparam int FULL_NEXTH    = STORE_BYTES - 2 - NEXTH_OFS;
    localparam int FULL_OPT_NH   = STORE_BYTES - 2 - OPT_NH_OFS;
    localparam int FULL_OPT_TYPE = STORE_BYTES - 2 - OPT_TYPE_OFS;
    localparam int FULL_OPT_ALEN = STORE_BYTES - 2 - OPT_ALEN_OFS;
    localparam int OUT_TAP       = STORE_BYTES - 1;

    t_mode        r_edit_mode;
    logic [63:0]  r_cust_high;
    logic [63:0]  r_cust_low;
    t_byte        r_type_code;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [POS_W-1:0]   r_count, n_count;
    logic               r_last_pending, n_last_pending;
    t_status            r_status, n_status;
    logic               r_hdr_mod, n_hdr_mod;
    logic               r_opt_gen, n_opt_gen;
    logic               r_addr_upd, n_addr_upd;
    logic               r_flag, n_flag;
    logic [15:0]        r_plen, n_plen;
    t_byte              r_nexth, n_nexth;
    t_byte              r_opt_nh, n_opt_nh;

    logic               r_out_valid, n_out_valid;
    t_byte              r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;
    logic               r_out_flag, n_out_flag;
    t_status            r_out_status, n_out_status;

    t_chain             w_cells;
    t_chain_ctl         w_ctl;
    logic               w_out_free;
    logic               w_in_ready;
    logic               w_accept;
    logic [POS_W-1:0]   w_pos_next;
    logic               w_hbh;
    logic               w_match;
    logic               w_in_addr;
    logic [3:0]         w_addr_k;
    t_byte              w_emit_byte;
    logic               w_emit_flag;
    logic [8*ADDR_BYTES-1:0] w_addr;

    coe_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .o_cells (w_cells)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_mode <= MODE_ADD;
            r_cust_high <= '0;
            r_cust_low  <= '0;
            r_type_code <= 8'd30;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_EDIT_MODE: r_edit_mode <= t_mode'(i_cfg.data[1:0]);
                CFG_CUST_HIGH: r_cust_high <= i_cfg.data;
                CFG_CUST_LOW:  r_cust_low  <= i_cfg.data;
                CFG_TYPE_CODE: r_type_code <= i_cfg.data[7:0];
                default:       r_type_code <= r_type_code;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign w_addr      = {r_cust_high, r_cust_low};

    always_comb begin
        w_in_addr   = (r_idx >= IDX_W'(ADDR_OFS)) && (r_idx < IDX_W'(ADDR_END));
        w_addr_k    = 4'(r_idx - IDX_W'(ADDR_OFS));
        w_emit_byte = w_cells[OUT_TAP];
        if (r_hdr_mod) begin
            if (r_idx == IDX_W'(PLEN_HI_OFS)) begin
                w_emit_byte = r_plen[15:8];
            end else if (r_idx == IDX_W'(PLEN_LO_OFS)) begin
                w_emit_byte = r_plen[7:0];
            end else if (r_idx == IDX_W'(NEXTH_OFS)) begin
                w_emit_byte = r_nexth;
            end
        end
        if (r_opt_gen && r_idx >= IDX_W'(OPT_NH_OFS)) begin
            if (r_idx == IDX_W'(OPT_NH_OFS)) begin
                w_emit_byte = r_opt_nh;
            end else if (r_idx == IDX_W'(OPT_LEN_OFS)) begin
                w_emit_byte = OPT_LEN_CODE;
            end else if (r_idx == IDX_W'(OPT_TYPE_OFS)) begin
                w_emit_byte = r_type_code;
            end else if (r_idx == IDX_W'(OPT_ALEN_OFS)) begin
                w_emit_byte = ADDR_LEN_CODE;
            end else if (w_in_addr) begin
                w_emit_byte = addr_byte(w_addr, w_addr_k);
            end else begin
                w_emit_byte = '0;
            end
        end
        if (r_addr_upd && w_in_addr) begin
            w_emit_byte = addr_byte(w_addr, w_addr_k);
        end
        w_emit_flag = r_flag && w_in_addr;
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == S_BUFFER) || ((r_state == S_PASS) && w_out_free);
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_pos_next = r_pos + POS_W'(1);
    assign w_hbh      = w_cells[FULL_NEXTH] == '0;
    assign w_match    = (w_cells[FULL_OPT_TYPE] == r_type_code) &&
                        (w_cells[FULL_OPT_ALEN] == ADDR_LEN_CODE);

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_idx          = r_idx;
        n_count        = r_count;
        n_last_pending = r_last_pending;
        n_status       = r_status;
        n_hdr_mod      = r_hdr_mod;
        n_opt_gen      = r_opt_gen;
        n_addr_upd     = r_addr_upd;
        n_flag         = r_flag;
        n_plen         = r_plen;
        n_nexth        = r_nexth;
        n_opt_nh       = r_opt_nh;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_byte     = r_out_byte;
        n_out_last     = r_out_last;
        n_out_flag     = r_out_flag;
        n_out_status   = r_out_status;
        w_ctl.shift    = 1'b0;
        w_ctl.din      = i_in.in_byte;

        case (r_state)
            S_BUFFER: begin
                if (w_accept) begin
                    w_ctl.shift    = 1'b1;
                    n_pos          = w_pos_next;
                    n_idx          = '0;
                    n_count        = POS_W'(STORE_BYTES);
                    n_last_pending = i_in.in_last;
                    n_hdr_mod      = 1'b0;
                    n_opt_gen      = 1'b0;
                    n_addr_upd     = 1'b0;
                    n_flag         = 1'b0;
                    if (w_pos_next == POS_W'(IP_HEADER_BYTES) &&
                        (r_edit_mode == MODE_ADD ||
                         (r_edit_mode == MODE_UPDATE && w_cells[ADD_NEXTH] != '0))) begin
                        n_hdr_mod = 1'b1;
                        n_opt_gen = 1'b1;
                        n_plen    = {w_cells[ADD_PLEN_HI], w_cells[ADD_PLEN_LO]} +
                                    16'(OPTION_HEADER_BYTES);
                        n_nexth   = '0;
                        n_opt_nh  = w_cells[ADD_NEXTH];
                        n_state   = S_ALIGN;
                    end else if (w_pos_next == POS_W'(STORE_BYTES)) begin
                        n_state = S_EMIT;
                        case (r_edit_mode)
                            MODE_STRIP: begin
                                if (!w_hbh) begin
                                    n_status = STAT_NO_HBH;
                                end else begin
                                    n_hdr_mod = 1'b1;
                                    n_count   = POS_W'(IP_HEADER_BYTES);
                                    n_plen    = {w_cells[FULL_PLEN_HI], w_cells[FULL_PLEN_LO]} -
                                                16'(OPTION_HEADER_BYTES);
                                    n_nexth   = w_cells[FULL_OPT_NH];
                                end
                            end
                            MODE_EXTRACT: begin
                                if (!w_hbh) begin
                                    n_status = STAT_NO_HBH;
                                end else if (!w_match) begin
                                    n_status = STAT_WRONG_OPT;
                                end
                                n_flag = w_hbh && w_match;
                            end
                            MODE_UPDATE: begin
                                if (w_hbh && w_match) begin
                                    n_addr_upd = 1'b1;
                                end else if (w_hbh) begin
                                    n_hdr_mod = 1'b1;
                                    n_opt_gen = 1'b1;
                                    n_plen    = {w_cells[FULL_PLEN_HI], w_cells[FULL_PLEN_LO]};
                                    n_nexth   = '0;
                                    n_opt_nh  = w_cells[FULL_OPT_NH];
                                end
                            end
                            default: begin
                                n_flag = 1'b0;
                            end
                        endcase
                    end else if (i_in.in_last) begin
                        n_status = STAT_SHORT;
                        n_count  = w_pos_next;
                        n_state  = S_ALIGN;
                    end
                end
            end
            S_ALIGN: begin
                w_ctl.shift = 1'b1;
                w_ctl.din   = '0;
                n_pos       = w_pos_next;
                if (w_pos_next == POS_W'(STORE_BYTES)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_ctl.shift  = 1'b1;
                    w_ctl.din    = '0;
                    n_idx        = r_idx + IDX_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_byte   = w_emit_byte;
                    n_out_flag   = w_emit_flag;
                    n_out_last   = 1'b0;
                    n_out_status = STAT_OK;
                    if (POS_W'(r_idx) + POS_W'(1) == r_count) begin
                        if (r_last_pending) begin
                            n_out_last   = 1'b1;
                            n_out_status = r_status;
                            n_status     = STAT_OK;
                            n_pos        = '0;
                            n_state      = S_BUFFER;
                        end else begin
                            n_state = S_PASS;
                        end
                    end
                end
            end
            S_PASS: begin
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = i_in.in_byte;
                    n_out_flag   = 1'b0;
                    n_out_last   = i_in.in_last;
                    n_out_status = i_in.in_last ? r_status : STAT_OK;
                    if (i_in.in_last) begin
                        n_status = STAT_OK;
                        n_pos    = '0;
                        n_state  = S_BUFFER;
                    end
                end
            end
            default: begin
                n_state = S_BUFFER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_BUFFER;
            r_pos          <= '0;
            r_status       <= STAT_OK;
            r_last_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pos          <= n_pos;
            r_status       <= n_status;
            r_last_pending <= n_last_pending;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_count      <= n_count;
        r_hdr_mod    <= n_hdr_mod;
        r_opt_gen    <= n_opt_gen;
        r_addr_upd   <= n_addr_upd;
        r_flag       <= n_flag;
        r_plen       <= n_plen;
        r_nexth      <= n_nexth;
        r_opt_nh     <= n_opt_nh;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_flag   <= n_out_flag;
        r_out_status <= n_out_status;
    end

    assign i_in.ready              = w_in_ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.out_byte          = r_out_byte;
    assign o_out.out_last          = r_out_last;
    assign o_out.is_custodian_byte = r_out_flag;
    assign o_out.edit_status       = r_out_status;

    `COE_ASSERT_ALWAYS(a_pos_bound, r_pos <= POS_W'(STORE_BYTES),
        "Byte position ran past the cell row.")
    `COE_ASSERT_IMPLY(a_emit_range, r_state == S_EMIT, POS_W'(r_idx) < r_count,
        "Unload index ran past the item count.")
    `COE_ASSERT_NEXT(a_align_done, r_state == S_ALIGN && w_pos_next == POS_W'(STORE_BYTES),
        r_state == S_EMIT, "Alignment did not hand over to the unload.")
    `COE_ASSERT_NEXT(a_pass_restart, r_state == S_PASS && w_accept && i_in.in_last,
        r_state == S_BUFFER && r_pos == '0, "Final byte did not restart buffering.")

endmodule

// ----- rtl/core/coe_cell.sv -----
module coe_cell
    import coe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_din,
    output t_byte o_q
);

    t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_din;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/coe_chain.sv -----
module coe_chain
    import coe_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    output t_chain     o_cells
);

    t_chain w_cells;

    for (genvar k = 0; k < STORE_BYTES; k++) begin : g_cell
        t_byte w_din;
        if (k == 0) begin : g_head
            assign w_din = i_ctl.din;
        end else begin : g_body
            assign w_din = w_cells[k-1];
        end
        coe_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_din   (w_din),
            .o_q     (w_cells[k])
        );
    end

    assign o_cells = w_cells;

endmodule

// ----- verif/ipv6_custody_option_editor_top_tb.sv -----
module ipv6_custody_option_editor_top_tb;
    import coe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CYCLE_LIMIT     = 500000;
    localparam int    LONG_HOLD       = 400;
    localparam int    ITEM_TARGET     = 100;
    localparam int    TAIL_ITEMS      = 20;
    localparam t_byte RESET_TYPE_CODE = 8'h1E;

    typedef enum int {
        PK_FOREIGN,
        PK_MATCH,
        PK_BAD_TYPE,
        PK_BAD_LEN,
        PK_NOISE
    } pkt_kind_e;

    typedef struct packed {
        t_byte   data;
        logic    last;
        logic    cust;
        t_status status;
    } out_item_t;

    class custody_edit_sb;
        t_mode       mode;
        logic [63:0] cust_hi;
        logic [63:0] cust_lo;
        t_byte       type_code;
        t_byte       hdr[STORE_BYTES];
        int          fill;
        bit          passing;
        t_status     pkt_status;
        out_item_t   expected[$];
        int          errors;

        function new();
            mode       = MODE_ADD;
            cust_hi    = '0;
            cust_lo    = '0;
            type_code  = RESET_TYPE_CODE;
            fill       = 0;
            passing    = 0;
            pkt_status = STAT_OK;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] d);
            case (idx)
                CFG_EDIT_MODE: mode = t_mode'(d[1:0]);
                CFG_CUST_HIGH: cust_hi = d;
                CFG_CUST_LOW:  cust_lo = d;
                CFG_TYPE_CODE: type_code = d[7:0];
            endcase
        endfunction

        function t_byte cust_byte(int k);
            logic [127:0] a;
            a = {cust_hi, cust_lo};
            return a[127 - 8 * k -: 8];
        endfunction

        function logic [15:0] stored_len();
            return {hdr[PLEN_HI_OFS], hdr[PLEN_LO_OFS]};
        endfunction

        function void put(t_byte b, logic f);
            out_item_t e;
            e.data   = b;
            e.last   = 1'b0;
            e.cust   = f;
            e.status = STAT_OK;
            expected.push_back(e);
        endfunction

        function void put_header(t_byte nh, logic [15:0] plen);
            t_byte b;
            for (int i = 0; i < IP_HEADER_BYTES; i++) begin
                b = hdr[i];
                if (i == PLEN_HI_OFS) b = plen[15:8];
                if (i == PLEN_LO_OFS) b = plen[7:0];
                if (i == NEXTH_OFS) b = nh;
                put(b, 1'b0);
            end
        endfunction

        function void put_option(t_byte nh);
            put(nh, 1'b0);
            put(OPT_LEN_CODE, 1'b0);
            put(type_code, 1'b0);
            put(ADDR_LEN_CODE, 1'b0);
            for (int k = 0; k < ADDR_BYTES; k++) put(cust_byte(k), 1'b0);
            for (int k = ADDR_END; k < STORE_BYTES; k++) put(8'h00, 1'b0);
        endfunction

        function void put_held(int count, bit flag);
            for (int i = 0; i < count; i++)
                put(hdr[i], flag && i >= ADDR_OFS && i < ADDR_END);
        endfunction

        function void decide_full();
            bit hbh;
            bit match;
            hbh   = (hdr[NEXTH_OFS] == 8'h00);
            match = (hdr[OPT_TYPE_OFS] == type_code) && (hdr[OPT_ALEN_OFS] == ADDR_LEN_CODE);
            case (mode)
                MODE_STRIP: begin
                    if (!hbh) begin
                        pkt_status = STAT_NO_HBH;
                        put_held(STORE_BYTES, 1'b0);
                    end else begin
                        put_header(hdr[OPT_NH_OFS], stored_len() - 16'(OPTION_HEADER_BYTES));
                    end
                end
                MODE_EXTRACT: begin
                    if (!hbh) pkt_status = STAT_NO_HBH;
                    else if (!match) pkt_status = STAT_WRONG_OPT;
                    put_held(STORE_BYTES, hbh && match);
                end
                MODE_UPDATE: begin
                    if (hbh && match) begin
                        for (int i = 0; i < STORE_BYTES; i++)
                            put((i >= ADDR_OFS && i < ADDR_END) ? cust_byte(i - ADDR_OFS) : hdr[i],
                                1'b0);
                    end else if (hbh) begin
                        put_header(8'h00, stored_len());
                        put_option(hdr[OPT_NH_OFS]);
                    end else begin
                        put_held(STORE_BYTES, 1'b0);
                    end
                end
                default: put_held(STORE_BYTES, 1'b0);
            endcase
        endfunction

        function void note_in_byte(t_byte b, logic last);
            int        base;
            out_item_t e;
            base = expected.size();
            if (passing) begin
                put(b, 1'b0);
            end else begin
                hdr[fill] = b;
                fill++;
                if (fill == IP_HEADER_BYTES &&
                    (mode == MODE_ADD || (mode == MODE_UPDATE && hdr[NEXTH_OFS] != 8'h00))) begin
                    put_header(8'h00, stored_len() + 16'(OPTION_HEADER_BYTES));
                    put_option(hdr[NEXTH_OFS]);
                    passing = 1;
                end else if (fill == STORE_BYTES) begin
                    decide_full();
                    passing = 1;
                end else if (last) begin
                    pkt_status = STAT_SHORT;
                    put_held(fill, 1'b0);
                end
            end
            if (last) begin
                if (expected.size() > base) begin
                    e = expected[expected.size() - 1];
                    e.last = 1'b1;
                    e.status = pkt_status;
                    expected[expected.size() - 1] = e;
                end
                fill       = 0;
                passing    = 0;
                pkt_status = STAT_OK;
            end
        endfunction

        function void check_out_byte(t_byte b, logic last, logic cust, logic [1:0] st);
            out_item_t e;
            if (expected.size() == 0) begin
                $error("out_byte %02h arrived with nothing expected", b);
                errors++;
                return;
            end
            e = expected.pop_front();
            if (b !== e.data) begin
                $error("out_byte expected %02h actual %02h", e.data, b);
                errors++;
            end
            if (last !== e.last) begin
                $error("out_last expected %0d actual %0d", e.last, last);
                errors++;
            end
            if (cust !== e.cust) begin
                $error("is_custodian_byte expected %0d actual %0d", e.cust, cust);
                errors++;
            end
            if (st !== 2'(e.status)) begin
                $error("edit_status expected %0d actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    coe_in_if  in_ch ();
    coe_out_if out_ch ();
    coe_cfg_if cfg_ch ();

    ipv6_custody_option_editor_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    custody_edit_sb sb = new();
    t_byte          cur_code = RESET_TYPE_CODE;
    bit             idle_on = 1'b1;
    bit             want_long_hold = 1'b0;
    int             cycles = 0;
    int             sent = 0;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL ipv6_custody_option_editor_top");
            $finish;
        end
    end

    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_out_byte(out_ch.out_byte, out_ch.out_last,
                                  out_ch.is_custodian_byte, out_ch.edit_status);
            if (hold == 0 && want_long_hold) begin
                want_long_hold = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 6);
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [63:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
    endtask

    task automatic apply_settings(t_mode m, logic [63:0] hi, logic [63:0] lo, t_byte code);
        write_reg(CFG_EDIT_MODE, 64'(m));
        write_reg(CFG_CUST_HIGH, hi);
        write_reg(CFG_CUST_LOW, lo);
        write_reg(CFG_TYPE_CODE, 64'(code));
        cfg_ch.valid <= 1'b0;
        cur_code = code;
    endtask

    task automatic apply_random_settings();
        t_mode       m;
        logic [63:0] hi;
        logic [63:0] lo;
        t_byte       code;
        int          r;
        m = t_mode'($urandom_range(0, 3));
        r = $urandom_range(0, 3);
        hi = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
        r = $urandom_range(0, 3);
        lo = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
        r = $urandom_range(0, 7);
        code = (r < 2) ? RESET_TYPE_CODE : (r == 2) ? 8'h00 : (r == 3) ? 8'hFF :
               t_byte'($urandom);
        apply_settings(m, hi, lo, code);
    endtask

    task automatic send_byte(t_byte b, logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_in_byte(b, last);
        sent++;
    endtask

    task automatic send_pkt(int len, pkt_kind_e kind, logic [15:0] plen);
        t_byte bytes[$];
        for (int i = 0; i < len; i++) bytes.push_back(t_byte'($urandom));
        if (kind != PK_NOISE) begin
            if (len > NEXTH_OFS)
                bytes[NEXTH_OFS] = (kind == PK_FOREIGN) ? t_byte'($urandom_range(1, 255)) : 8'h00;
            if (len > PLEN_LO_OFS) begin
                bytes[PLEN_HI_OFS] = plen[15:8];
                bytes[PLEN_LO_OFS] = plen[7:0];
            end
            if (len > OPT_ALEN_OFS && kind != PK_FOREIGN) begin
                bytes[OPT_TYPE_OFS] = (kind == PK_BAD_TYPE) ?
                    (cur_code ^ t_byte'($urandom_range(1, 255))) : cur_code;
                bytes[OPT_ALEN_OFS] = (kind == PK_BAD_LEN) ?
                    (ADDR_LEN_CODE ^ t_byte'($urandom_range(1, 255))) : ADDR_LEN_CODE;
            end
        end
        for (int i = 0; i < len; i++) send_byte(bytes[i], i == len - 1);
    endtask

    task automatic send_random_pkt(int max_len);
        int          r;
        int          len;
        pkt_kind_e   kind;
        logic [15:0] plen;
        r = $urandom_range(0, 9);
        len = (r < 2) ? $urandom_range(1, IP_HEADER_BYTES - 1) :
              (r < 4) ? $urandom_range(IP_HEADER_BYTES, STORE_BYTES - 1) :
              (r < 7) ? STORE_BYTES : $urandom_range(STORE_BYTES + 1, STORE_BYTES + 8);
        if (len > max_len) len = max_len;
        r = $urandom_range(0, 9);
        kind = (r < 5) ? PK_MATCH : (r < 7) ? PK_FOREIGN : (r == 7) ? PK_BAD_TYPE :
               (r == 8) ? PK_BAD_LEN : PK_NOISE;
        r = $urandom_range(0, 4);
        plen = (r == 0) ? 16'($urandom_range(0, OPTION_HEADER_BYTES - 1)) :
               (r == 1) ? 16'($urandom_range(16'hFFE8, 16'hFFFF)) : 16'($urandom);
        send_pkt(len, kind, plen);
    endtask

    task automatic finish_phase();
        in_ch.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int len;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_EDIT_MODE;
        cfg_ch.data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        want_long_hold = 1'b1;
        send_pkt(IP_HEADER_BYTES + 1, PK_FOREIGN, 16'hFFF0);
        send_pkt(2, PK_NOISE, 16'h0000);
        finish_phase();

        while (sent < ITEM_TARGET - TAIL_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            apply_random_settings();
            send_random_pkt(ITEM_TARGET - sent);
            finish_phase();
        end

        idle_on = 1'b0;
        apply_random_settings();
        len = (ITEM_TARGET - sent > TAIL_ITEMS) ? ITEM_TARGET - sent : TAIL_ITEMS;
        send_pkt(len, PK_MATCH, 16'($urandom));
        finish_phase();

        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("PASS ipv6_custody_option_editor_top");
        end else begin
            $display("FAIL ipv6_custody_option_editor_top");
        end
        $finish;
    end

endmodule
